// ----- src/fifo_queue_with_min_query_defines.svh -----
`ifndef FIFO_QUEUE_WITH_MIN_QUERY_DEFINES_SVH
`define FIFO_QUEUE_WITH_MIN_QUERY_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define FQMQ_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its cause.
`define FQMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/fqmq_pkg.sv -----
`default_nettype none

package fqmq_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int DATA_W        = 32;

   typedef enum logic [1:0] {
      OP_ENQ = 2'd0,
      OP_DEQ = 2'd1,
      OP_MIN = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DEQ,
      S_SCAN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic scan_start;
      logic scan_next;
   } store_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } store_stat_type;

endpackage

`default_nettype wire

// ----- src/fqmq_store.sv -----
`default_nettype none

module fqmq_store import fqmq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int AW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire store_cmd_type            cmd,
   input  wire logic signed [DATA_W-1:0] wr_data,
   output store_stat_type                stat,
   output logic [CW-1:0]                 count,
   output logic signed [DATA_W-1:0]      rd_data
);

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [AW-1:0] scan_ff, scan_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] rd_addr;
   logic          rd_en;

   function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
      ptr_next = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign rd_en   = cmd.pop | cmd.scan_start | cmd.scan_next;
   assign rd_addr = cmd.scan_next ? scan_ff : head_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      scan_in  = scan_ff;
      count_in = count_ff;
      if (cmd.push) begin
         tail_in  = ptr_next(tail_ff);
         count_in = count_ff + 1'b1;
      end
      if (cmd.pop) begin
         head_in  = ptr_next(head_ff);
         count_in = count_ff - 1'b1;
      end
      if (cmd.scan_start) begin
         scan_in = ptr_next(head_ff);
      end
      if (cmd.scan_next) begin
         scan_in = ptr_next(scan_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         scan_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         scan_ff  <= scan_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[tail_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign count      = count_ff;
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(DEPTH));

endmodule

`default_nettype wire

// ----- src/fqmq_ctrl.sv -----
`default_nettype none

module fqmq_ctrl import fqmq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [1:0]               req_opcode,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DATA_W-1:0]      rsp_result_value,
   output logic [1:0]                    rsp_status,
   output store_cmd_type                 cmd,
   input  wire store_stat_type           stat,
   input  wire logic [CW-1:0]            count,
   input  wire logic signed [DATA_W-1:0] rd_data
);

   state_type                state_ff, state_in;
   logic [CW-1:0]            left_ff, left_in;
   logic                     first_ff, first_in;
   logic signed [DATA_W-1:0] acc_ff, acc_in;
   logic signed [DATA_W-1:0] res_ff, res_in;
   status_type               st_ff, st_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] min_now;

   assign min_now = (first_ff || (rd_data < acc_ff)) ? rd_data : acc_ff;

   always_comb begin
      state_in      = state_ff;
      left_in       = left_ff;
      first_in      = first_ff;
      acc_in        = acc_ff;
      res_in        = res_ff;
      st_in         = st_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      cmd           = '0;
      req_ready     = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               res_in   = '0;
               st_in    = ST_OK;
               state_in = S_DONE;
               unique case (req_opcode)
                  OP_ENQ: begin
                     if (stat.full) begin
                        st_in = ST_FULL;
                     end else begin
                        cmd.push = 1'b1;
                     end
                  end
                  OP_DEQ: begin
                     if (stat.empty) begin
                        st_in = ST_EMPTY;
                     end else begin
                        cmd.pop  = 1'b1;
                        state_in = S_DEQ;
                     end
                  end
                  OP_MIN: begin
                     if (stat.empty) begin
                        st_in = ST_EMPTY;
                     end else begin
                        cmd.scan_start = 1'b1;
                        left_in        = count - 1'b1;
                        first_in       = 1'b1;
                        state_in       = S_SCAN;
                     end
                  end
                  default: begin
                     st_in = ST_OK;
                  end
               endcase
            end
         end
         S_DEQ: begin
            res_in   = rd_data;
            st_in    = ST_OK;
            state_in = S_DONE;
         end
         S_SCAN: begin
            acc_in   = min_now;
            first_in = 1'b0;
            if (left_ff != '0) begin
               cmd.scan_next = 1'b1;
               left_in       = left_ff - 1'b1;
            end else begin
               res_in   = min_now;
               st_in    = ST_OK;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_ff;
               rsp_status_in = st_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b0;
         left_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
         left_ff      <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff        <= acc_in;
      res_ff        <= res_in;
      st_ff         <= st_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

`default_nettype wire

// ----- src/fifo_queue_with_min_query.sv -----
// Channel   Ports                                  Transfer
// request   req_opcode, req_data_value             req_valid && req_ready
// response  rsp_result_value, rsp_status           rsp_valid && rsp_ready
//
// Enqueue, failed operations and the unused opcode go from idle to the done
// state; dequeue reads in its own state first. Minimum scans the n held values:
// one memory read port feeds one signed comparator, one entry per cycle.
// Reset clears pointers and count; the storage is not cleared.
// A finished result waits in the output register; a new request is taken
// meanwhile and its result is held until the output register is free.
`default_nettype none
`include "fifo_queue_with_min_query_defines.svh"

module fifo_queue_with_min_query import fqmq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [1:0]               req_opcode,
   input  wire logic signed [DATA_W-1:0] req_data_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DATA_W-1:0]      rsp_result_value,
   output logic [1:0]                    rsp_status
);

   localparam int CW = $clog2(DEPTH + 1);

   store_cmd_type            cmd;
   store_stat_type           stat;
   logic [CW-1:0]            count;
   logic signed [DATA_W-1:0] rd_data;

   fqmq_store #(.DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .wr_data (req_data_value),
      .stat    (stat),
      .count   (count),
      .rd_data (rd_data)
   );

   fqmq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .cmd              (cmd),
      .stat             (stat),
      .count            (count),
      .rd_data          (rd_data)
   );

   `FQMQ_ASSERT_SAME(a_count_bound, 1'b1, count <= CW'(DEPTH), "entry count beyond depth")
   `FQMQ_ASSERT_NEXT(a_busy_after_take, req_valid && req_ready, !req_ready, "request taken while busy")
   `FQMQ_ASSERT_NEXT(a_enq_grows, req_valid && req_ready && req_opcode == OP_ENQ && !stat.full, count == CW'($past(count) + 1'b1), "enqueue did not grow count")
   `FQMQ_ASSERT_NEXT(a_deq_shrinks, req_valid && req_ready && req_opcode == OP_DEQ && !stat.empty, count == CW'($past(count) - 1'b1), "dequeue did not shrink count")

endmodule

`default_nettype wire
